// ===== rtl/core/epm_pkg.sv =====
// shared types and constants of the exact pattern matcher
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

  localparam int unsigned SYM_W     = 7;
  localparam int unsigned START_W   = 16;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned QUEUE_D   = 3;
  localparam int unsigned QCNT_W    = 2;

  localparam logic [START_W-1:0] START_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } epm_op_e;

  typedef struct packed {
    logic pat_shift;
    logic win_shift;
    logic win_clear;
  } epm_cell_ctrl_t;

  typedef struct packed {
    logic               is_summary;
    logic [COUNT_W-1:0] match_count;
    logic [START_W-1:0] match_start;
  } epm_result_t;

  typedef struct packed {
    logic first;
    logic second;
  } epm_push_t;

endpackage

`default_nettype wire

// ===== rtl/core/epm_cell.sv =====
// one matcher cell: a pattern character, a text window character and their compare
`timescale 1ns / 1ps
`default_nettype none

module epm_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire epm_pkg::epm_cell_ctrl_t   ctrl_i,
  input  wire logic [epm_pkg::SYM_W-1:0] pat_i,
  input  wire logic [epm_pkg::SYM_W-1:0] win_i,
  output      logic [epm_pkg::SYM_W-1:0] pat_o,
  output      logic [epm_pkg::SYM_W-1:0] win_o,
  output      logic                      hit_o
);

  logic [epm_pkg::SYM_W-1:0] pat_q;
  logic [epm_pkg::SYM_W-1:0] win_q;

  // pattern characters need no reset, only written ones are looked at
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.win_clear) begin
      win_q <= '0;
    end else if (ctrl_i.win_shift) begin
      win_q <= win_i;
    end
  end

  // compare against the character this cell holds after the shift
  assign hit_o = (win_i == pat_q);
  assign pat_o = pat_q;
  assign win_o = win_q;

endmodule

`default_nettype wire

// ===== rtl/core/epm_out_queue.sv =====
// three-entry result queue between the cell row and the output stream
`timescale 1ns / 1ps
`default_nettype none

module epm_out_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire epm_pkg::epm_push_t    push_i,
  input  wire epm_pkg::epm_result_t  first_i,
  input  wire epm_pkg::epm_result_t  second_i,
  output      logic                  space_o,
  output      logic                  valid_o,
  input  wire logic                  ready_i,
  output      epm_pkg::epm_result_t  head_o
);

  epm_pkg::epm_result_t               slot_q [epm_pkg::QUEUE_D];
  epm_pkg::epm_result_t               slot_d [epm_pkg::QUEUE_D];
  logic [epm_pkg::QCNT_W-1:0]         count_q;
  logic [epm_pkg::QCNT_W-1:0]         count_d;
  logic [epm_pkg::QCNT_W-1:0]         base;
  logic                               pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign space_o = (count_q <= epm_pkg::QCNT_W'(1));
  assign head_o  = slot_q[0];

  always_comb begin
    base = pop ? (count_q - epm_pkg::QCNT_W'(1)) : count_q;
    for (int i = 0; i < epm_pkg::QUEUE_D; i++) begin
      if (pop && (i < epm_pkg::QUEUE_D - 1)) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push_i.first && (epm_pkg::QCNT_W'(i) == base)) begin
        slot_d[i] = first_i;
      end else if (push_i.second && (epm_pkg::QCNT_W'(i) == base + epm_pkg::QCNT_W'(1))) begin
        slot_d[i] = second_i;
      end
    end
    count_d = base + epm_pkg::QCNT_W'(push_i.first) + epm_pkg::QCNT_W'(push_i.second);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < epm_pkg::QUEUE_D; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/exact_pattern_matcher.sv =====
// top level of the exact pattern matcher: cell row, position and count, result queue
//
// channel  | dir | payload
// s_axis   | in  | tdata[6:0] symbol, tuser operation (0 load, 1 text), tlast last
// m_axis   | out | tdata[15:0] match_start, tdata[32:16] match_count, tuser is_summary
//
// one character per cycle while tready is high: every cell compares its window character with its
// pattern character in the cycle the character is taken, and the row result
// goes straight into the result queue
// tready drops while the queue holds two or more results (output stalled)
// reset empties the pattern and the text window, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module exact_pattern_matcher #(
  parameter int unsigned      MAX_PATTERN = 32,
  parameter longint unsigned  MAX_TEXT    = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] symbol, [7] zero
  input  wire logic        s_axis_tuser,   // [0] operation
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,   // [15:0] match_start, [32:16] match_count, [39:33] zero
  output      logic        m_axis_tuser    // [0] is_summary
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned POS_W = $clog2(MAX_TEXT + 1);
  localparam int unsigned CMP_W = (POS_W > epm_pkg::START_W) ? POS_W : epm_pkg::START_W;

  logic [LEN_W-1:0]               length_q;
  logic [LEN_W-1:0]               length_d;
  logic                           restart_q;
  logic [POS_W-1:0]               pos_q;
  logic [POS_W-1:0]               pos_next;
  logic [epm_pkg::COUNT_W-1:0]    count_q;
  logic [epm_pkg::COUNT_W-1:0]    count_next;

  logic                           accept;
  logic                           is_text;
  logic                           space;
  logic                           match;
  logic [LEN_W-1:0]               load_base;
  logic [POS_W-1:0]               start_full;
  logic [CMP_W-1:0]               start_cmp;
  logic [epm_pkg::START_W-1:0]    start_sat;
  logic [epm_pkg::SYM_W-1:0]      sym;

  epm_pkg::epm_cell_ctrl_t        ctrl;
  epm_pkg::epm_push_t             push;
  epm_pkg::epm_result_t           first;
  epm_pkg::epm_result_t           second;
  epm_pkg::epm_result_t           head;

  logic [epm_pkg::SYM_W-1:0]      pat_chain [MAX_PATTERN];
  logic [epm_pkg::SYM_W-1:0]      win_chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]         hit;
  logic [MAX_PATTERN-1:0]         cell_ok;

  assign sym           = s_axis_tdata[epm_pkg::SYM_W-1:0];
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_text       = (epm_pkg::epm_op_e'(s_axis_tuser) == epm_pkg::OP_TEXT);

  // a restarting load begins a fresh pattern, a full pattern ignores more characters
  assign load_base = restart_q ? '0 : length_q;

  always_comb begin
    ctrl.pat_shift = accept && !is_text && (load_base < LEN_W'(MAX_PATTERN));
    ctrl.win_shift = accept && is_text;
    ctrl.win_clear = accept && (!is_text || s_axis_tlast);
    length_d = length_q;
    if (accept && !is_text) begin
      length_d = ctrl.pat_shift ? (load_base + LEN_W'(1)) : load_base;
    end
  end

  // cell k holds the pattern character that must line up with the k-th newest text character
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [epm_pkg::SYM_W-1:0] pat_in;
    logic [epm_pkg::SYM_W-1:0] win_in;
    if (k == 0) begin : g_head
      assign pat_in = sym;
      assign win_in = sym;
    end else begin : g_body
      assign pat_in = pat_chain[k-1];
      assign win_in = win_chain[k-1];
    end
    epm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pat_i  (pat_in),
      .win_i  (win_in),
      .pat_o  (pat_chain[k]),
      .win_o  (win_chain[k]),
      .hit_o  (hit[k])
    );
    assign cell_ok[k] = hit[k] || (LEN_W'(k) >= length_q);
  end

  always_comb begin
    pos_next = (pos_q != POS_W'(MAX_TEXT)) ? (pos_q + POS_W'(1)) : pos_q;
    match    = (length_q != '0) && (pos_next >= POS_W'(length_q)) && (&cell_ok);
    start_full = pos_next - POS_W'(length_q);
    start_cmp  = CMP_W'(start_full);
    start_sat  = (start_cmp > CMP_W'(epm_pkg::START_MAX)) ? epm_pkg::START_MAX
                                                          : start_cmp[epm_pkg::START_W-1:0];
    count_next = (match && (count_q != epm_pkg::COUNT_MAX)) ? (count_q + epm_pkg::COUNT_W'(1))
                                                           : count_q;
  end

  always_comb begin
    first  = '{is_summary: 1'b0, match_count: count_next, match_start: start_sat};
    second = '{is_summary: 1'b1, match_count: count_next, match_start: '0};
    push.first  = ctrl.win_shift && (match || s_axis_tlast);
    push.second = ctrl.win_shift && match && s_axis_tlast;
    if (!match) begin
      first = second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q  <= '0;
      restart_q <= 1'b1;
      pos_q     <= '0;
      count_q   <= '0;
    end else begin
      length_q <= length_d;
      if (accept && !is_text) begin
        restart_q <= s_axis_tlast;
      end
      if (ctrl.win_clear) begin
        pos_q   <= '0;
        count_q <= '0;
      end else if (ctrl.win_shift) begin
        pos_q   <= pos_next;
        count_q <= count_next;
      end
    end
  end

  epm_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first),
    .second_i (second),
    .space_o  (space),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {7'd0, head.match_count, head.match_start};
  assign m_axis_tuser = head.is_summary;

endmodule

`default_nettype wire
